// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Depends on nothing; included by the top level only.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property a implies b in the same cycle, checked on clk outside reset.
`define ASSERT_IMPL(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("assertion failed");

// Property a implies b in the cycle after a.
`define ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("assertion failed");

`endif

// ===== hdl/fsca_pkg.sv =====
// Package for the free segment coalescing allocator: widths, codes, types.
// Depends on nothing.
package fsca_pkg;
  localparam int AddrW = 63;
  localparam int SizeW = 31;
  localparam int DefMaxSegments = 64;
  localparam logic [AddrW-1:0] AddrMax = {AddrW{1'b1}};
  localparam logic [AddrW-1:0] GrowStep = 63'd1000000000;
  localparam logic [AddrW-1:0] Slack = 63'd3;

  typedef enum logic [1:0] {
    KIND_APPEND  = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_FIND    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_EXACT    = 4'd0,
    ST_LARGER   = 4'd1,
    ST_EXTENDED = 4'd2,
    ST_MPREV    = 4'd3,
    ST_MBOTH    = 4'd4,
    ST_MNEXT    = 4'd5,
    ST_INSERTED = 4'd6,
    ST_NOTPLACE = 4'd7,
    ST_FULL     = 4'd8,
    ST_EMPTY    = 4'd9
  } status_t;

  // Outcome of comparing one table entry against the current word.
  typedef struct packed {
    logic adj_prev;   // entry last + 1 == seg_start
    logic adj_next;   // entry first == seg_end + 1
    logic later;      // seg_start < entry first
    logic absorb;     // entry first <= seg_end + 1
    logic exact;      // entry length == size
    logic larger;     // entry length > size + 3
  } cmp_t;
endpackage

// ===== hdl/fsca_cmp.sv =====
// Shared compare unit: checks one table entry against the current word.
// Depends on fsca_pkg.
module fsca_cmp (
  input  logic [fsca_pkg::AddrW-1:0] ent_first,
  input  logic [fsca_pkg::AddrW-1:0] ent_last,
  input  logic [fsca_pkg::AddrW-1:0] seg_start,
  input  logic [fsca_pkg::AddrW-1:0] seg_end,
  input  logic [fsca_pkg::SizeW-1:0] request_size,
  output fsca_pkg::cmp_t             res
);
  import fsca_pkg::*;
  logic [AddrW:0] e1, b1, len, sz, szs;
  always_comb begin
    e1  = {1'b0, ent_last} + 64'd1;
    b1  = {1'b0, seg_end} + 64'd1;
    len = e1 - {1'b0, ent_first};
    sz  = {{(AddrW+1-SizeW){1'b0}}, request_size};
    szs = sz + {1'b0, Slack};
    res.adj_prev = (e1 == {1'b0, seg_start});
    res.adj_next = ({1'b0, ent_first} == b1);
    res.later    = (seg_start < ent_first);
    res.absorb   = ({1'b0, ent_first} <= b1);
    res.exact    = (e1 >= {1'b0, ent_first}) && (len == sz);
    res.larger   = (e1 >= {1'b0, ent_first}) && (len > szs);
  end
endmodule

// ===== hdl/free_segment_coalescing_allocator_core.sv =====
// Top level of the free segment coalescing allocator: sequencer and table.
// Depends on fsca_pkg, fsca_cmp and assert_macros.svh.
//
//  channel | handshake         | fields
//  input   | start / busy      | kind, seg_start, seg_end, request_size
//  result  | done (one cycle)  | status, slot, found_start, found_end
//
// One word scans the table one entry per cycle through the shared compare
// unit; an insert or a remove then shifts one entry at a time, each with a
// read state, then a write state. Busy is shortest when the word ends at
// once (full, empty or unused kind) and longest for an insert at slot 0 of
// a table one short of full. The table memory's single registered read port
// sets that pace. Reset empties the table at once; the receiver cannot stall.
`include "assert_macros.svh"
module free_segment_coalescing_allocator_core #(
  parameter int MAX_SEGMENTS = fsca_pkg::DefMaxSegments
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 kind,
  input  logic [fsca_pkg::AddrW-1:0] seg_start,
  input  logic [fsca_pkg::AddrW-1:0] seg_end,
  input  logic [fsca_pkg::SizeW-1:0] request_size,
  output logic                       done,
  output logic [3:0]                 status,
  output logic [5:0]                 slot,
  output logic [fsca_pkg::AddrW-1:0] found_start,
  output logic [fsca_pkg::AddrW-1:0] found_end
);
  import fsca_pkg::*;
  localparam int IW = $clog2(MAX_SEGMENTS);
  localparam int CW = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_READ  = 10'b0000000010,
    S_EVAL  = 10'b0000000100,
    S_ABS   = 10'b0000001000,
    S_SHR   = 10'b0000010000,
    S_SHRW  = 10'b0000100000,
    S_SHL   = 10'b0001000000,
    S_SHLW  = 10'b0010000000,
    S_FETCH = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t state;
  logic [AddrW-1:0] mem_first [MAX_SEGMENTS];
  logic [AddrW-1:0] mem_last  [MAX_SEGMENTS];
  logic [AddrW-1:0] rd_first, rd_last;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;      // scan or shift position
  logic [IW-1:0] tgt;      // slot reported in the result
  logic [1:0] op;
  logic [AddrW-1:0] a, b;
  logic [SizeW-1:0] size;
  logic have;
  logic [IW-1:0] pick;
  logic [3:0] st;
  logic absorbing;
  logic [AddrW-1:0] merged_first;
  logic [AddrW-1:0] merged_last;

  // Memory port: one write and one registered read per cycle.
  logic we;
  logic [IW-1:0] waddr, raddr;
  logic [AddrW-1:0] wfirst, wlast;
  cmp_t cmp;

  fsca_cmp u_cmp (
    .ent_first(rd_first), .ent_last(rd_last), .seg_start(a), .seg_end(b),
    .request_size(size), .res(cmp)
  );

  always_ff @(posedge clk) begin
    if (we) begin
      mem_first[waddr] <= wfirst;
      mem_last[waddr]  <= wlast;
    end
    rd_first <= mem_first[raddr];
    rd_last  <= mem_last[raddr];
  end

  logic [CW-1:0] idx1;
  logic last_ent;
  assign idx1 = idx + 1'b1;
  assign last_ent = (idx1 == count);

  always_comb begin
    we = 1'b0;
    waddr = idx[IW-1:0];
    wfirst = a;
    wlast = b;
    raddr = idx[IW-1:0];
    unique case (state)
      S_IDLE:  raddr = '0;
      S_EVAL: begin
        raddr = idx1[IW-1:0];
        if (op == KIND_RELEASE) begin
          if (cmp.adj_prev) begin
            we = 1'b1; wfirst = rd_first; wlast = b;
          end else if (cmp.adj_next) begin
            we = 1'b1; wfirst = a; wlast = rd_last;
          end
        end else if (last_ent && !cmp.exact && !cmp.larger && !have) begin
          // Nothing fits: grow the last entry while it is on the read port.
          we = 1'b1; wfirst = rd_first;
          wlast = (rd_last > AddrMax - GrowStep) ? AddrMax : rd_last + GrowStep;
        end
      end
      S_ABS: begin
        we = absorbing;
        waddr = tgt;
        wfirst = merged_first;
        wlast = absorbing ? rd_last : merged_last;
      end
      S_SHR: raddr = idx[IW-1:0] - 1'b1;
      S_SHRW: begin
        we = 1'b1; wfirst = rd_first; wlast = rd_last;
        raddr = idx[IW-1:0] - 1'b1;
        if (idx == CW'(tgt)) begin
          wfirst = a; wlast = b;
        end
      end
      S_SHL: raddr = idx1[IW-1:0];
      S_SHLW: begin
        we = 1'b1; wfirst = rd_first; wlast = rd_last;
        raddr = idx1[IW-1:0];
      end
      S_FETCH: raddr = tgt;
      S_OUT: raddr = tgt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          op <= kind; a <= seg_start; b <= seg_end; size <= request_size;
          idx <= '0; have <= 1'b0; pick <= '0; tgt <= '0;
          unique case (kind_t'(kind))
            KIND_APPEND: begin
              if (count >= CW'(MAX_SEGMENTS)) begin
                st <= ST_FULL; state <= S_OUT;
              end else begin
                tgt <= count[IW-1:0]; idx <= count; st <= ST_INSERTED;
                state <= S_SHRW;
              end
            end
            KIND_RELEASE: begin
              if (count == '0) begin st <= ST_NOTPLACE; state <= S_OUT; end
              else state <= S_READ;
            end
            KIND_FIND: begin
              if (count == '0) begin st <= ST_EMPTY; state <= S_OUT; end
              else state <= S_READ;
            end
            default: begin st <= ST_NOTPLACE; state <= S_OUT; end
          endcase
        end
        S_READ: state <= S_EVAL;
        S_EVAL: begin
          tgt <= idx[IW-1:0];
          idx <= idx1;
          if (op == KIND_RELEASE) begin
            if (cmp.adj_prev) begin
              merged_first <= rd_first;
              merged_last <= b; st <= ST_MPREV; state <= S_ABS;
              absorbing <= 1'b0;
            end else if (cmp.adj_next) begin
              st <= ST_MNEXT; state <= S_FETCH;
            end else if (cmp.later) begin
              if (count >= CW'(MAX_SEGMENTS)) begin
                st <= ST_FULL; state <= S_OUT;
              end else begin
                st <= ST_INSERTED; idx <= count; state <= S_SHR;
              end
            end else if (last_ent) begin
              st <= ST_NOTPLACE; state <= S_OUT;
            end
          end else begin
            if (cmp.exact) begin
              st <= ST_EXACT; state <= S_FETCH;
            end else begin
              if (cmp.larger && !have) begin have <= 1'b1; pick <= idx[IW-1:0]; end
              if (last_ent) begin
                state <= S_FETCH;
                if (have || cmp.larger) begin
                  st <= ST_LARGER;
                  tgt <= have ? pick : idx[IW-1:0];
                end else st <= ST_EXTENDED;
              end
            end
          end
        end
        // Wait for the next entry's read, then decide whether to absorb it.
        S_ABS: begin
          if (absorbing) begin
            absorbing <= 1'b0;
            st <= ST_MBOTH;
            idx <= idx;
            if (idx1 >= count) begin
              count <= count - 1'b1; state <= S_FETCH;
            end else state <= S_SHL;
          end else if (idx < count && cmp.absorb) begin
            absorbing <= 1'b1;
          end else state <= S_FETCH;
        end
        S_SHR: state <= S_SHRW;
        S_SHRW: begin
          if (idx == CW'(tgt)) begin
            count <= count + 1'b1; state <= S_FETCH;
          end else begin
            idx <= idx - 1'b1; state <= S_SHR;
          end
        end
        S_SHL: state <= S_SHLW;
        S_SHLW: begin
          if (idx1 + 1'b1 >= count) begin
            count <= count - 1'b1; state <= S_FETCH;
          end else begin
            idx <= idx1; state <= S_SHL;
          end
        end
        S_FETCH: state <= S_OUT;
        S_OUT: begin
          done <= 1'b1;
          status <= st;
          if (st <= ST_INSERTED) begin
            slot <= 6'(tgt); found_start <= rd_first; found_end <= rd_last;
          end else begin
            slot <= '0; found_start <= '0; found_end <= '0;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  `ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `ASSERT_IMPL(a_count_range, 1'b1, count <= CW'(MAX_SEGMENTS))
  `ASSERT_NEXT(a_done_pulse, done, !done)
endmodule

// ===== test/fsca_checker.sv =====
`timescale 1ns / 100ps
// Checker for the free segment coalescing allocator: keeps its own copy of the
// segment table, predicts each result word and compares it with the block.
// Depends on fsca_pkg.
module fsca_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic                       busy,
  input  logic [1:0]                 kind,
  input  logic [fsca_pkg::AddrW-1:0] seg_start,
  input  logic [fsca_pkg::AddrW-1:0] seg_end,
  input  logic [fsca_pkg::SizeW-1:0] request_size,
  input  logic                       done,
  input  logic [3:0]                 status,
  input  logic [5:0]                 slot,
  input  logic [fsca_pkg::AddrW-1:0] found_start,
  input  logic [fsca_pkg::AddrW-1:0] found_end,
  output int                         failures,
  output int                         pending
);
  import fsca_pkg::*;

  localparam int TableDepth = DefMaxSegments;

  typedef struct packed {
    status_t          st;
    logic [5:0]       slot;
    logic [AddrW-1:0] first;
    logic [AddrW-1:0] last;
  } outcome_t;

  outcome_t         expected_words[$];
  logic [AddrW-1:0] tab_first[TableDepth];
  logic [AddrW-1:0] tab_last[TableDepth];
  int               tab_count;

  initial begin
    failures = 0;
    pending = 0;
    tab_count = 0;
  end

  // Statuses without a segment report zeros in every other field.
  function automatic outcome_t report(status_t st, int s);
    outcome_t o;
    o.st = st;
    if (st <= ST_INSERTED) begin
      o.slot = s[5:0];
      o.first = tab_first[s];
      o.last = tab_last[s];
    end else begin
      o.slot = '0;
      o.first = '0;
      o.last = '0;
    end
    return o;
  endfunction

  function automatic outcome_t release_segment(logic [AddrW-1:0] a, logic [AddrW-1:0] b);
    logic [AddrW:0] b_next;
    b_next = {1'b0, b} + 1'b1;
    for (int i = 0; i < tab_count; i++) begin
      // Adjacency is computed one bit wider so the top address follows nothing.
      if ({1'b0, tab_last[i]} + 1'b1 == {1'b0, a}) begin
        tab_last[i] = b;
        if (i + 1 < tab_count && {1'b0, tab_first[i+1]} <= b_next) begin
          tab_last[i] = tab_last[i+1];
          for (int j = i + 1; j + 1 < tab_count; j++) begin
            tab_first[j] = tab_first[j+1];
            tab_last[j] = tab_last[j+1];
          end
          tab_count--;
          return report(ST_MBOTH, i);
        end
        return report(ST_MPREV, i);
      end
      if ({1'b0, tab_first[i]} == b_next) begin
        tab_first[i] = a;
        return report(ST_MNEXT, i);
      end
      if (a < tab_first[i]) begin
        if (tab_count >= TableDepth) return report(ST_FULL, 0);
        for (int j = tab_count; j > i; j--) begin
          tab_first[j] = tab_first[j-1];
          tab_last[j] = tab_last[j-1];
        end
        tab_first[i] = a;
        tab_last[i] = b;
        tab_count++;
        return report(ST_INSERTED, i);
      end
    end
    return report(ST_NOTPLACE, 0);
  endfunction

  function automatic outcome_t find_fit(logic [SizeW-1:0] size);
    logic [AddrW:0] end_next;
    logic [AddrW:0] len;
    logic [AddrW:0] want;
    bit             have;
    int             pick;
    int             n;
    have = 0;
    pick = 0;
    want = {{(AddrW-SizeW+1){1'b0}}, size};
    if (tab_count == 0) return report(ST_EMPTY, 0);
    for (int i = 0; i < tab_count; i++) begin
      end_next = {1'b0, tab_last[i]} + 1'b1;
      // A segment whose end lies before its start never fits.
      if (end_next < {1'b0, tab_first[i]}) continue;
      len = end_next - {1'b0, tab_first[i]};
      if (len == want) return report(ST_EXACT, i);
      if (len > want + Slack && !have) begin
        have = 1;
        pick = i;
      end
    end
    if (have) return report(ST_LARGER, pick);
    n = tab_count - 1;
    if (tab_last[n] > AddrMax - GrowStep) tab_last[n] = AddrMax;
    else tab_last[n] = tab_last[n] + GrowStep;
    return report(ST_EXTENDED, n);
  endfunction

  function automatic outcome_t apply_word(kind_t k, logic [AddrW-1:0] a,
                                          logic [AddrW-1:0] b, logic [SizeW-1:0] size);
    case (k)
      KIND_APPEND: begin
        if (tab_count >= TableDepth) return report(ST_FULL, 0);
        tab_first[tab_count] = a;
        tab_last[tab_count] = b;
        tab_count++;
        return report(ST_INSERTED, tab_count - 1);
      end
      KIND_RELEASE: return release_segment(a, b);
      KIND_FIND: return find_fit(size);
      default: return report(ST_NOTPLACE, 0);
    endcase
  endfunction

  always @(posedge clk) begin
    outcome_t want;
    if (!rst) begin
      if (done) begin
        if (expected_words.size() == 0) begin
          failures++;
          if (failures <= 10)
            $display("%t: result word with none expected: status %0d slot %0d", $realtime,
                     status, slot);
        end else begin
          want = expected_words.pop_front();
          if (status != want.st || slot != want.slot || found_start != want.first ||
              found_end != want.last) begin
            failures++;
            if (failures <= 10)
              $display("%t: mismatch: status %0d/%0d slot %0d/%0d start %h/%h end %h/%h",
                       $realtime, want.st, status, want.slot, slot, want.first, found_start,
                       want.last, found_end);
          end
        end
      end
      if (start && !busy)
        expected_words.push_back(apply_word(kind_t'(kind), seg_start, seg_end, request_size));
      pending = expected_words.size();
    end
  end
endmodule

// ===== test/tb_free_segment_coalescing_allocator_core.sv =====
`timescale 1ns / 100ps
// Testbench top for the free segment coalescing allocator: clock, reset,
// stimulus words and verdict. Depends on fsca_pkg, the core and fsca_checker.
module tb_free_segment_coalescing_allocator_core;
  import fsca_pkg::*;

  localparam int RandomWords = 900;

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  logic [1:0]       kind;
  logic [AddrW-1:0] seg_start;
  logic [AddrW-1:0] seg_end;
  logic [SizeW-1:0] request_size;
  logic             done;
  logic [3:0]       status;
  logic [5:0]       slot;
  logic [AddrW-1:0] found_start;
  logic [AddrW-1:0] found_end;
  int               failures;
  int               pending;

  logic [AddrW-1:0] placed_first[$];
  logic [AddrW-1:0] placed_last[$];
  logic [AddrW-1:0] cursor;
  int               n_append, n_release, n_find, n_other;

  free_segment_coalescing_allocator_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .seg_start(seg_start), .seg_end(seg_end), .request_size(request_size),
    .done(done), .status(status), .slot(slot), .found_start(found_start),
    .found_end(found_end)
  );

  fsca_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .seg_start(seg_start), .seg_end(seg_end), .request_size(request_size),
    .done(done), .status(status), .slot(slot), .found_start(found_start),
    .found_end(found_end), .failures(failures), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_free_segment_coalescing_allocator_core: errors");
    $finish;
  end

  // Holds one word on the inputs until the block takes it.
  task automatic send(kind_t k, logic [AddrW-1:0] a, logic [AddrW-1:0] b,
                      logic [SizeW-1:0] size);
    bit taken;
    taken = 0;
    @(negedge clk);
    start = 1;
    kind = k;
    seg_start = a;
    seg_end = b;
    request_size = size;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    case (k)
      KIND_APPEND: n_append++;
      KIND_RELEASE: n_release++;
      KIND_FIND: n_find++;
      default: n_other++;
    endcase
  endtask

  task automatic pause(int cycles);
    @(negedge clk);
    start = 0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  function automatic logic [AddrW-1:0] any_addr();
    return AddrW'({$urandom, $urandom});
  endfunction

  function automatic logic [SizeW-1:0] any_size();
    return SizeW'($urandom);
  endfunction

  task automatic random_word();
    int               pick;
    int               len;
    int               idx;
    logic [AddrW-1:0] a;
    logic [AddrW-1:0] b;
    logic [SizeW-1:0] size;
    pick = $urandom_range(0, 99);
    len = $urandom_range(1, 40);
    idx = placed_first.size() ? $urandom_range(0, placed_first.size() - 1) : 0;
    if (pick < 20 || placed_first.size() == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        a = any_addr();
        b = any_addr();
      end else begin
        a = cursor;
        b = cursor + len - 1;
        cursor = b + 1 + $urandom_range(0, 30);
        placed_first.push_back(a);
        placed_last.push_back(b);
      end
      send(KIND_APPEND, a, b, any_size());
    end else if (pick < 65) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = placed_last[idx] + 1;
          b = a + len - 1;
        end
        3, 4, 5: begin
          b = placed_first[idx] - 1;
          a = b - len + 1;
        end
        6, 7: begin
          a = placed_last[idx] + 2 + $urandom_range(0, 5);
          b = a + $urandom_range(0, 3);
        end
        8: begin
          // Fill the gap to the next appended segment so both neighbors merge.
          a = placed_last[idx] + 1;
          b = idx + 1 < placed_first.size() ? placed_first[idx+1] - 1 : a;
        end
        default: begin
          a = any_addr();
          b = any_addr();
        end
      endcase
      send(KIND_RELEASE, a, b, any_size());
    end else if (pick < 95) begin
      case ($urandom_range(0, 3))
        0: size = SizeW'(placed_last[idx] - placed_first[idx] + 1);
        1: size = SizeW'($urandom_range(1, 50));
        2: size = SizeW'($urandom_range(1, 1000));
        default: size = any_size();
      endcase
      if (size == 0) size = 1;
      send(KIND_FIND, any_addr(), any_addr(), size);
    end else begin
      send(KIND_NONE, any_addr(), any_addr(), any_size());
    end
  endtask

  initial begin
    rst = 1;
    start = 0;
    kind = KIND_APPEND;
    seg_start = '0;
    seg_end = '0;
    request_size = '0;
    n_append = 0;
    n_release = 0;
    n_find = 0;
    n_other = 0;
    cursor = 63'd1000;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Empty table, unused kind, then small merges and inserts by hand.
    send(KIND_FIND, '0, '0, 31'd1);
    send(KIND_RELEASE, 63'd10, 63'd20, 31'd1);
    send(KIND_NONE, AddrMax, AddrMax, {SizeW{1'b1}});
    send(KIND_APPEND, 63'd10, 63'd19, 31'd1);
    send(KIND_APPEND, 63'd40, 63'd49, 31'd1);
    send(KIND_FIND, '0, '0, 31'd10);
    send(KIND_FIND, '0, '0, 31'd3);
    send(KIND_RELEASE, 63'd20, 63'd39, 31'd1);
    send(KIND_RELEASE, 63'd0, 63'd5, 31'd1);
    send(KIND_RELEASE, 63'd6, 63'd9, 31'd1);
    send(KIND_RELEASE, 63'd100, 63'd109, 31'd1);
    send(KIND_RELEASE, 63'd50, 63'd59, 31'd1);
    send(KIND_RELEASE, 63'd70, 63'd79, 31'd1);
    send(KIND_RELEASE, 63'd65, 63'd69, 31'd1);
    send(KIND_APPEND, AddrMax, 63'd0, 31'd1);
    send(KIND_FIND, '0, '0, {SizeW{1'b1}});
    send(KIND_APPEND, AddrMax - 2, AddrMax - 2, 31'd1);
    send(KIND_FIND, '0, '0, 31'd1000000);
    send(KIND_FIND, '0, '0, 31'd1);
    send(KIND_APPEND, AddrMax, AddrMax, 31'd1);

    for (int i = 0; i < RandomWords; i++) begin
      if (i < RandomWords - 100 && $urandom_range(0, 3) == 0) pause($urandom_range(1, 11));
      if (i == RandomWords / 2) begin
        @(negedge clk);
        start = 0;
        while (pending != 0) @(negedge clk);
      end
      random_word();
    end
    @(negedge clk);
    start = 0;
    while (pending != 0) @(negedge clk);
    repeat (2 * DefMaxSegments + 20) @(negedge clk);

    $display("Sent %0d appends, %0d releases, %0d finds and %0d unused-kind words",
             n_append, n_release, n_find, n_other);
    $display("through empty, merging, inserting, extending and full-table states.");
    if (failures == 0) begin
      $display("tb_free_segment_coalescing_allocator_core: clean");
    end else begin
      $display("tb_free_segment_coalescing_allocator_core: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/fsca_pkg.sv
hdl/fsca_cmp.sv
hdl/free_segment_coalescing_allocator_core.sv
test/fsca_checker.sv
test/tb_free_segment_coalescing_allocator_core.sv
